FILE: design/lgsm_pkg.sv
// Shared widths, types, register indices and mode codes of the logic-gated sample modulator.
package lgsm_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int FRAC_BITS = 20;
  localparam int CFG_DATA_WIDTH = 24;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int MODE_WIDTH = 4;

  // Logic is true above one half; a change counts when it exceeds 0.01.
  localparam int HALF_LEVEL = 1 << (FRAC_BITS - 1);
  localparam int CHANGE_LIMIT = (1 << FRAC_BITS) / 100;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [MODE_WIDTH-1:0] mode_t;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  typedef logic [CFG_DATA_WIDTH-1:0] cfg_data_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
  localparam sample_t HIGH_LEVEL_RESET = sample_t'(1 << FRAC_BITS);

  localparam cfg_index_t REG_MODE = 2'd0;
  localparam cfg_index_t REG_HIGH_LEVEL = 2'd1;
  localparam cfg_index_t REG_LOW_LEVEL = 2'd2;

  localparam mode_t MODE_REPLACE = 4'd0;
  localparam mode_t MODE_MULTIPLY = 4'd1;
  localparam mode_t MODE_ADD = 4'd2;
  localparam mode_t MODE_INVERT = 4'd3;
  localparam mode_t MODE_HOLD_ON_FALSE = 4'd4;
  localparam mode_t MODE_ZERO_ON_FALSE = 4'd5;
  localparam mode_t MODE_CROSSFADE = 4'd6;
  localparam mode_t MODE_REMAP = 4'd7;
  localparam mode_t MODE_SAMPLE_HOLD = 4'd8;

endpackage

FILE: design/lgsm_in_if.sv
// Input channel: control value, audio sample and buffer-start flag.
interface lgsm_in_if;
  logic valid;
  logic ready;
  lgsm_pkg::sample_t logic_value;
  lgsm_pkg::sample_t sample_in;
  logic buffer_start;

  modport source (output valid, output logic_value, output sample_in,
                  output buffer_start, input ready);
  modport sink (input valid, input logic_value, input sample_in,
                input buffer_start, output ready);
endinterface

FILE: design/lgsm_out_if.sv
// Output channel: one modulated sample per word.
interface lgsm_out_if;
  logic valid;
  logic ready;
  lgsm_pkg::sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

FILE: design/logic_gated_sample_modulator_top.sv
// Top level of the logic-gated sample modulator.
// The block takes one word per clock when the output side is ready, and returns one
// modulated sample per word. A word is captured in an input register, goes through
// one multiplier, an adder and the mode select, and lands in the output register;
// the sustained rate is one word per cycle, limited only by the output side's ready.
// The held sample and previous logic value are updated as each word moves into the
// output register, so back-to-back words see the state left by the word before them.
// The user must write configuration only while idle; the block does not enforce it.
module logic_gated_sample_modulator_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  lgsm_pkg::cfg_index_t   wr_index,
  input  lgsm_pkg::cfg_data_t    wr_data,
  lgsm_in_if.sink                din,
  lgsm_out_if.source             dout
);

  localparam int SW = lgsm_pkg::SAMPLE_WIDTH;
  localparam int PROD_W = 2 * SW;
  localparam int MULQ_W = PROD_W - lgsm_pkg::FRAC_BITS;

  // Configuration registers.
  lgsm_pkg::mode_t   mode;
  lgsm_pkg::sample_t high_level;
  lgsm_pkg::sample_t low_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lgsm_pkg::MODE_REPLACE;
      high_level <= lgsm_pkg::HIGH_LEVEL_RESET;
      low_level <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        lgsm_pkg::REG_MODE:       mode <= wr_data[lgsm_pkg::MODE_WIDTH-1:0];
        lgsm_pkg::REG_HIGH_LEVEL: high_level <= wr_data[SW-1:0];
        lgsm_pkg::REG_LOW_LEVEL:  low_level <= wr_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic              s1_valid;
  lgsm_pkg::sample_t s1_logic;
  lgsm_pkg::sample_t s1_sample;
  logic              s1_start;

  logic              out_valid;
  lgsm_pkg::sample_t out_sample;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free = !out_valid || dout.ready;
  assign s1_fire = s1_valid && out_free;
  assign din.ready = !s1_valid || out_free;
  assign in_fire = din.valid && din.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_logic <= din.logic_value;
      s1_sample <= din.sample_in;
      s1_start <= din.buffer_start;
    end
  end

  // State carried from word to word.
  lgsm_pkg::sample_t held_sample;
  lgsm_pkg::sample_t previous_logic;
  lgsm_pkg::sample_t held_sample_next;
  lgsm_pkg::sample_t previous_logic_next;

  // Datapath between the input and output registers.
  logic signed [PROD_W-1:0] product;
  logic signed [MULQ_W-1:0] mul_q;
  lgsm_pkg::sample_t        mul_sat;
  logic signed [SW:0]       sum;
  lgsm_pkg::sample_t        sum_sat;
  lgsm_pkg::sample_t        neg_sat;
  logic signed [SW:0]       diff;
  logic [SW:0]              diff_abs;
  logic                     truth;
  logic                     changed;
  lgsm_pkg::sample_t        result;

  always_comb begin
    product = s1_logic * s1_sample;
    // Dropping the fraction bits of a two's complement product floors it.
    mul_q = product[PROD_W-1:lgsm_pkg::FRAC_BITS];
    if (mul_q[MULQ_W-1:SW-1] == '0 || mul_q[MULQ_W-1:SW-1] == '1) begin
      mul_sat = mul_q[SW-1:0];
    end else begin
      mul_sat = mul_q[MULQ_W-1] ? lgsm_pkg::SAMPLE_MIN : lgsm_pkg::SAMPLE_MAX;
    end

    sum = {s1_logic[SW-1], s1_logic} + {s1_sample[SW-1], s1_sample};
    if (sum[SW] == sum[SW-1]) begin
      sum_sat = sum[SW-1:0];
    end else begin
      sum_sat = sum[SW] ? lgsm_pkg::SAMPLE_MIN : lgsm_pkg::SAMPLE_MAX;
    end

    neg_sat = (s1_sample == lgsm_pkg::SAMPLE_MIN) ? lgsm_pkg::SAMPLE_MAX : -s1_sample;

    truth = s1_logic > lgsm_pkg::sample_t'(lgsm_pkg::HALF_LEVEL);

    diff = {s1_logic[SW-1], s1_logic} - {previous_logic[SW-1], previous_logic};
    diff_abs = diff[SW] ? (SW + 1)'(-diff) : (SW + 1)'(diff);
    changed = diff_abs > (SW + 1)'(lgsm_pkg::CHANGE_LIMIT);
  end

  always_comb begin
    held_sample_next = held_sample;
    previous_logic_next = previous_logic;
    case (mode) inside
      lgsm_pkg::MODE_MULTIPLY, lgsm_pkg::MODE_CROSSFADE: result = mul_sat;
      lgsm_pkg::MODE_ADD:           result = sum_sat;
      lgsm_pkg::MODE_INVERT:        result = truth ? neg_sat : s1_sample;
      lgsm_pkg::MODE_ZERO_ON_FALSE: result = truth ? s1_sample : '0;
      lgsm_pkg::MODE_REMAP:         result = truth ? high_level : low_level;
      lgsm_pkg::MODE_HOLD_ON_FALSE: begin
        if (s1_start || truth) begin
          held_sample_next = s1_sample;
          result = s1_sample;
        end else begin
          result = held_sample;
        end
      end
      lgsm_pkg::MODE_SAMPLE_HOLD: begin
        previous_logic_next = s1_logic;
        if (s1_start || changed) begin
          held_sample_next = s1_sample;
          result = s1_sample;
        end else begin
          result = held_sample;
        end
      end
      default: result = s1_logic;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_sample <= '0;
      previous_logic <= '0;
    end else if (s1_fire) begin
      held_sample <= held_sample_next;
      previous_logic <= previous_logic_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_sample <= result;
    end
  end

  assign dout.valid = out_valid;
  assign dout.sample_out = out_sample;

  // A full pipeline with a stalled output must not take another word.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !dout.ready) |-> !din.ready)
    else $error("input accepted while both stages are stalled");

  // A result only appears after a word sat in the input stage.
  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("output word without a word in the input stage");

  // Modes without state leave the held values alone.
  a_state_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && mode != lgsm_pkg::MODE_HOLD_ON_FALSE
     && mode != lgsm_pkg::MODE_SAMPLE_HOLD)
    |=> ($stable(held_sample) && $stable(previous_logic)))
    else $error("state changed in a stateless mode");

  // A buffer start in a hold mode loads the sample and passes it through.
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_start && (mode == lgsm_pkg::MODE_HOLD_ON_FALSE
     || mode == lgsm_pkg::MODE_SAMPLE_HOLD))
    |=> (held_sample == $past(s1_sample) && out_sample == $past(s1_sample)))
    else $error("buffer start did not load the held sample");

endmodule

FILE: dv/tb_logic_gated_sample_modulator_top.sv
// Self-checking testbench for the logic-gated sample modulator top level.
`timescale 1ns / 1ps

module tb_logic_gated_sample_modulator_top;

  localparam lgsm_pkg::mode_t MODE_UNDEF_TOP = '1;

  typedef struct {
    lgsm_pkg::mode_t   mode;
    lgsm_pkg::sample_t logic_v;
    lgsm_pkg::sample_t sample_v;
    logic              start;
    logic              known;
    lgsm_pkg::sample_t want;
  } vector_row_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  lgsm_pkg::cfg_index_t wr_index;
  lgsm_pkg::cfg_data_t wr_data;

  lgsm_in_if din_ch ();
  lgsm_out_if dout_ch ();

  logic_gated_sample_modulator_top dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .din      (din_ch),
    .dout     (dout_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register settings and block state as the checker tracks them.
  lgsm_pkg::mode_t cur_mode = lgsm_pkg::MODE_REPLACE;
  lgsm_pkg::sample_t cur_high = lgsm_pkg::HIGH_LEVEL_RESET;
  lgsm_pkg::sample_t cur_low = '0;
  lgsm_pkg::sample_t exp_held = '0;
  lgsm_pkg::sample_t exp_prev_logic = '0;

  lgsm_pkg::sample_t pending_samples[$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic known_now = 1'b0;
  lgsm_pkg::sample_t known_value = '0;
  lgsm_pkg::sample_t last_logic = '0;

  vector_row_t directed_rows [25] = '{
    '{lgsm_pkg::MODE_REPLACE, lgsm_pkg::SAMPLE_MAX, 0, 1'b0, 1'b1, lgsm_pkg::SAMPLE_MAX},
    '{lgsm_pkg::MODE_REPLACE, lgsm_pkg::SAMPLE_MIN, 0, 1'b0, 1'b1, lgsm_pkg::SAMPLE_MIN},
    '{lgsm_pkg::MODE_MULTIPLY, lgsm_pkg::SAMPLE_MAX, lgsm_pkg::SAMPLE_MAX, 1'b0, 1'b1,
      lgsm_pkg::SAMPLE_MAX},
    '{lgsm_pkg::MODE_MULTIPLY, lgsm_pkg::SAMPLE_MIN, lgsm_pkg::SAMPLE_MIN, 1'b0, 1'b1,
      lgsm_pkg::SAMPLE_MAX},
    '{lgsm_pkg::MODE_MULTIPLY, lgsm_pkg::SAMPLE_MIN, lgsm_pkg::SAMPLE_MAX, 1'b0, 1'b1,
      lgsm_pkg::SAMPLE_MIN},
    '{lgsm_pkg::MODE_MULTIPLY, -1, 1, 1'b0, 1'b0, 0},
    '{lgsm_pkg::MODE_MULTIPLY, lgsm_pkg::HALF_LEVEL, lgsm_pkg::HALF_LEVEL, 1'b0, 1'b0, 0},
    '{lgsm_pkg::MODE_ADD, lgsm_pkg::SAMPLE_MAX, lgsm_pkg::SAMPLE_MAX, 1'b0, 1'b1,
      lgsm_pkg::SAMPLE_MAX},
    '{lgsm_pkg::MODE_ADD, lgsm_pkg::SAMPLE_MIN, lgsm_pkg::SAMPLE_MIN, 1'b0, 1'b1,
      lgsm_pkg::SAMPLE_MIN},
    '{lgsm_pkg::MODE_ADD, -300, 100, 1'b1, 1'b0, 0},
    '{lgsm_pkg::MODE_INVERT, lgsm_pkg::SAMPLE_MAX, lgsm_pkg::SAMPLE_MIN, 1'b0, 1'b1,
      lgsm_pkg::SAMPLE_MAX},
    '{lgsm_pkg::MODE_INVERT, lgsm_pkg::HALF_LEVEL, 12345, 1'b0, 1'b1, 12345},
    '{lgsm_pkg::MODE_INVERT, lgsm_pkg::HALF_LEVEL + 1, 12345, 1'b0, 1'b0, 0},
    '{lgsm_pkg::MODE_ZERO_ON_FALSE, lgsm_pkg::HALF_LEVEL, 777, 1'b0, 1'b1, 0},
    '{lgsm_pkg::MODE_ZERO_ON_FALSE, lgsm_pkg::SAMPLE_MAX, 777, 1'b0, 1'b1, 777},
    '{lgsm_pkg::MODE_CROSSFADE, lgsm_pkg::SAMPLE_MIN, lgsm_pkg::SAMPLE_MIN, 1'b0, 1'b1,
      lgsm_pkg::SAMPLE_MAX},
    '{lgsm_pkg::MODE_REMAP, lgsm_pkg::HALF_LEVEL + 1, 5, 1'b0, 1'b1,
      lgsm_pkg::HIGH_LEVEL_RESET},
    '{lgsm_pkg::MODE_REMAP, lgsm_pkg::SAMPLE_MIN, 5, 1'b0, 1'b1, 0},
    '{lgsm_pkg::MODE_HOLD_ON_FALSE, 0, 1000, 1'b1, 1'b1, 1000},
    '{lgsm_pkg::MODE_HOLD_ON_FALSE, 0, 2000, 1'b0, 1'b1, 1000},
    '{lgsm_pkg::MODE_HOLD_ON_FALSE, lgsm_pkg::SAMPLE_MAX, 3000, 1'b0, 1'b0, 0},
    '{lgsm_pkg::MODE_SAMPLE_HOLD, 0, 500, 1'b1, 1'b1, 500},
    '{lgsm_pkg::MODE_SAMPLE_HOLD, lgsm_pkg::CHANGE_LIMIT, 600, 1'b0, 1'b0, 0},
    '{lgsm_pkg::MODE_SAMPLE_HOLD, 2 * lgsm_pkg::CHANGE_LIMIT + 1, 700, 1'b0, 1'b0, 0},
    '{MODE_UNDEF_TOP, -5, 9, 1'b0, 1'b1, -5}
  };

  function automatic lgsm_pkg::sample_t clamp_sample(input logic signed [47:0] v);
    if (v > lgsm_pkg::SAMPLE_MAX) begin
      return lgsm_pkg::SAMPLE_MAX;
    end else if (v < lgsm_pkg::SAMPLE_MIN) begin
      return lgsm_pkg::SAMPLE_MIN;
    end
    return lgsm_pkg::sample_t'(v);
  endfunction

  // Computes the modulated sample for one word and advances the hold state.
  function automatic lgsm_pkg::sample_t modulated_sample(input lgsm_pkg::sample_t lv,
                                                         input lgsm_pkg::sample_t sv,
                                                         input logic st);
    logic signed [47:0] prod;
    logic signed [24:0] wide;
    logic truth;
    lgsm_pkg::sample_t r;
    truth = lv > lgsm_pkg::HALF_LEVEL;
    case (cur_mode) inside
      lgsm_pkg::MODE_MULTIPLY, lgsm_pkg::MODE_CROSSFADE: begin
        prod = lv * sv;
        r = clamp_sample(prod >>> lgsm_pkg::FRAC_BITS);
      end
      lgsm_pkg::MODE_ADD: begin
        wide = lv + sv;
        r = clamp_sample(wide);
      end
      lgsm_pkg::MODE_INVERT: begin
        wide = -sv;
        r = truth ? clamp_sample(wide) : sv;
      end
      lgsm_pkg::MODE_HOLD_ON_FALSE: begin
        if (st || truth) begin
          exp_held = sv;
        end
        r = exp_held;
      end
      lgsm_pkg::MODE_ZERO_ON_FALSE: r = truth ? sv : '0;
      lgsm_pkg::MODE_REMAP: r = truth ? cur_high : cur_low;
      lgsm_pkg::MODE_SAMPLE_HOLD: begin
        if (st) begin
          exp_held = sv;
        end else begin
          wide = lv - exp_prev_logic;
          if (wide < 0) begin
            wide = -wide;
          end
          if (wide > lgsm_pkg::CHANGE_LIMIT) begin
            exp_held = sv;
          end
        end
        exp_prev_logic = lv;
        r = exp_held;
      end
      default: r = lv;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input lgsm_pkg::sample_t got,
                                 input lgsm_pkg::sample_t want);
    err_count++;
    if (err_count <= 50) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    lgsm_pkg::sample_t want;
    if (!rst) begin
      if (dout_ch.valid && dout_ch.ready) begin
        if (pending_samples.size() == 0) begin
          report_mismatch("output word with nothing expected", dout_ch.sample_out, '0);
        end else begin
          want = pending_samples.pop_front();
          if (dout_ch.sample_out !== want) begin
            report_mismatch("sample_out", dout_ch.sample_out, want);
          end
        end
      end
      if (din_ch.valid && din_ch.ready) begin
        want = modulated_sample(din_ch.logic_value, din_ch.sample_in, din_ch.buffer_start);
        if (known_now) begin
          want = known_value;
        end
        pending_samples.push_back(want);
      end
    end
  end

  // Output side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      dout_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      dout_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(input lgsm_pkg::sample_t lv, input lgsm_pkg::sample_t sv,
                           input logic st, input logic known,
                           input lgsm_pkg::sample_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      din_ch.valid <= 1'b0;
    end
    @(negedge clk);
    din_ch.valid <= 1'b1;
    din_ch.logic_value <= lv;
    din_ch.sample_in <= sv;
    din_ch.buffer_start <= st;
    known_now = known;
    known_value = want;
    last_logic = lv;
    do @(posedge clk); while (!din_ch.ready);
  endtask

  // Stops offering words and waits until every expected sample has come back.
  task automatic wait_all_returned();
    @(negedge clk);
    din_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input lgsm_pkg::cfg_index_t idx, input lgsm_pkg::cfg_data_t val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      lgsm_pkg::REG_MODE: cur_mode = lgsm_pkg::mode_t'(val);
      lgsm_pkg::REG_HIGH_LEVEL: cur_high = lgsm_pkg::sample_t'(val);
      lgsm_pkg::REG_LOW_LEVEL: cur_low = lgsm_pkg::sample_t'(val);
      default: ;
    endcase
  endtask

  function automatic lgsm_pkg::sample_t pick_level();
    case ($urandom_range(3))
      0: return lgsm_pkg::SAMPLE_MAX;
      1: return lgsm_pkg::SAMPLE_MIN;
      default: return lgsm_pkg::sample_t'($urandom);
    endcase
  endfunction

  initial begin
    int words;
    int step;
    lgsm_pkg::sample_t lv;
    lgsm_pkg::sample_t sv;
    lgsm_pkg::mode_t seg_mode;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = lgsm_pkg::REG_MODE;
    wr_data = '0;
    din_ch.valid = 1'b0;
    din_ch.logic_value = '0;
    din_ch.sample_in = '0;
    din_ch.buffer_start = 1'b0;
    dout_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != cur_mode) begin
        wait_all_returned();
        write_reg(lgsm_pkg::REG_MODE, lgsm_pkg::cfg_data_t'(directed_rows[i].mode));
      end
      send_word(directed_rows[i].logic_v, directed_rows[i].sample_v, directed_rows[i].start,
                directed_rows[i].known, directed_rows[i].want);
    end

    // Four idling phases of four segments each, every segment with fresh settings.
    for (int seg = 0; seg < 16; seg++) begin
      case (seg / 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 50; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 50; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (seg < 9) begin
        seg_mode = lgsm_pkg::mode_t'((seg * 5) % 9);
      end else if (seg == 15) begin
        seg_mode = MODE_UNDEF_TOP;
      end else begin
        seg_mode = lgsm_pkg::mode_t'($urandom_range(MODE_UNDEF_TOP));
      end
      wait_all_returned();
      write_reg(lgsm_pkg::REG_MODE, lgsm_pkg::cfg_data_t'(seg_mode));
      write_reg(lgsm_pkg::REG_HIGH_LEVEL, lgsm_pkg::cfg_data_t'(pick_level()));
      write_reg(lgsm_pkg::REG_LOW_LEVEL, lgsm_pkg::cfg_data_t'(pick_level()));
      words = $urandom_range(40, 52);
      for (int w = 0; w < words; w++) begin
        if (w == 10 && seg == 1) begin
          hold_left = 200;
        end
        if (w == 10 && seg == 2) begin
          wait_all_returned();
        end
        // Logic values cluster near the truth threshold and the change limit.
        step = lgsm_pkg::CHANGE_LIMIT + $urandom_range(4) - 2;
        case ($urandom_range(5)) inside
          0, 1: lv = lgsm_pkg::sample_t'($urandom);
          2: lv = lgsm_pkg::sample_t'(lgsm_pkg::HALF_LEVEL + $urandom_range(4) - 2);
          3: lv = $urandom_range(1) ? lgsm_pkg::sample_t'(last_logic + step)
                                    : lgsm_pkg::sample_t'(last_logic - step);
          4: lv = lgsm_pkg::sample_t'(last_logic + $urandom_range(40) - 20);
          default: lv = $urandom_range(1) ? lgsm_pkg::SAMPLE_MAX : lgsm_pkg::SAMPLE_MIN;
        endcase
        if ($urandom_range(7) == 0) begin
          sv = $urandom_range(1) ? lgsm_pkg::SAMPLE_MAX : lgsm_pkg::SAMPLE_MIN;
        end else begin
          sv = lgsm_pkg::sample_t'($urandom);
        end
        send_word(lv, sv, $urandom_range(15) == 0, 1'b0, '0);
      end
    end

    wait_all_returned();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
